>>> sv/mfsc_pkg.sv
// ----------------------------------------------------------------------------
// mfsc_pkg
// Constants and the frame-length table for the MP3 frame sample counter.
// ----------------------------------------------------------------------------
package mfsc_pkg;

    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 32;
    localparam int SKIP_W  = 11;
    localparam int FILL_W  = 2;
    localparam int WIN_DEPTH = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_MASK  = 8'hE0;
    localparam logic [1:0]        LAYER_III  = 2'd1;
    localparam logic [1:0]        VER_MPEG1  = 2'd3;
    localparam logic [1:0]        VER_MPEG2  = 2'd2;
    localparam logic [1:0]        SRI_RESVD  = 2'd3;
    localparam logic [3:0]        BR_FREE    = 4'd0;
    localparam logic [3:0]        BR_BAD     = 4'd15;

    localparam logic [TOTAL_W-1:0] SAMPLES_MPEG1 = 32'd1152;
    localparam logic [TOTAL_W-1:0] SAMPLES_MPEG2 = 32'd576;

    // Header bytes already counted when the length is loaded into the skip counter.
    localparam logic [SKIP_W-1:0] HDR_BYTES = 11'd4;

    localparam int LEN_ROWS = 9;
    localparam int LEN_COLS = 14;

    // Frame length without padding, truncated.
    // Rows: MPEG-1 44.1/48/32 kHz, MPEG-2 22.05/24/16 kHz, MPEG-2.5 11.025/12/8 kHz.
    // Columns: bitrate index 1 through 14.
    localparam logic [SKIP_W-1:0] LEN_TABLE [0:LEN_ROWS-1][0:LEN_COLS-1] = '{
        '{11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
          11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044},
        '{11'd96,  11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
          11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960},
        '{11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
          11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440},
        '{11'd26,  11'd52,  11'd78,  11'd104, 11'd130, 11'd156, 11'd182,
          11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522},
        '{11'd24,  11'd48,  11'd72,  11'd96,  11'd120, 11'd144, 11'd168,
          11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480},
        '{11'd36,  11'd72,  11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
          11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720},
        '{11'd52,  11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
          11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044},
        '{11'd48,  11'd96,  11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
          11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960},
        '{11'd72,  11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
          11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440}
    };

endpackage

>>> sv/mp3_frame_sample_counter.sv
// ----------------------------------------------------------------------------
// mp3_frame_sample_counter
// Scans an MP3 byte stream for Layer III frame headers, skips each recognized
// frame and reports the total sample count when the last byte arrives.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------
//  in      | in_valid / in_stall | data_byte[7:0], last_byte
//  out     | out_valid/ out_stall| sample_total[31:0]
//
//  One byte is accepted every cycle while in_stall is low. The accepted byte
//  is loaded into the input register and, for a last byte, the total is then
//  loaded into the result register, from which it is presented.
//  The scan state (window, fill, skip counter, total) is updated as the byte
//  leaves the input register; the header check plus frame-length table lookup
//  feeds back into that state.
//  Reset (rst_n low, asynchronous) clears all control and scan state.
//  Only a last byte can wait in the input register: it waits while an earlier
//  total is still held and stalled at the output; in_stall then goes high.
// ----------------------------------------------------------------------------
module mp3_frame_sample_counter
    import mfsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TOTAL_W-1:0] sample_total
);

    // Input register
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_adv;
    logic              in_take;

    // Scan state
    logic [BYTE_W-1:0]  window_reg [0:WIN_DEPTH-1];
    logic [BYTE_W-1:0]  window_next [0:WIN_DEPTH-1];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // Result register
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    // Header decode
    logic [1:0]         hdr_ver;
    logic [1:0]         hdr_sri;
    logic [3:0]         hdr_br;
    logic [3:0]         len_row;
    logic [3:0]         len_col;
    logic               hdr_ok;
    logic [SKIP_W-1:0]  frame_len;
    logic [TOTAL_W-1:0] hdr_samples;

    // Advance the input register unless it holds a last byte that would
    // overwrite a total still waiting at the output.
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_adv)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Decode the candidate header held in the window.
    assign hdr_ver = window_reg[1][4:3];
    assign hdr_sri = window_reg[2][3:2];
    assign hdr_br  = window_reg[2][7:4];

    assign hdr_ok = (window_reg[0] == SYNC_BYTE)
                 && ((window_reg[1] & SYNC_MASK) == SYNC_MASK)
                 && (window_reg[1][2:1] == LAYER_III)
                 && (hdr_br != BR_FREE) && (hdr_br != BR_BAD)
                 && (hdr_sri != SRI_RESVD);

    always_comb
    begin
        if (hdr_ver == VER_MPEG1)
        begin
            len_row     = {2'b00, hdr_sri};
            hdr_samples = SAMPLES_MPEG1;
        end
        else if (hdr_ver == VER_MPEG2)
        begin
            len_row     = 4'd3 + {2'b00, hdr_sri};
            hdr_samples = SAMPLES_MPEG2;
        end
        else
        begin
            // Reserved version falls in with MPEG-2.5.
            len_row     = 4'd6 + {2'b00, hdr_sri};
            hdr_samples = SAMPLES_MPEG2;
        end
    end

    assign len_col   = hdr_br - 4'd1;
    // Out-of-range rows and columns only occur when hdr_ok is low.
    assign frame_len = ((len_row < 4'(LEN_ROWS)) && (len_col < 4'(LEN_COLS)))
                     ? LEN_TABLE[len_row][len_col] + {10'd0, window_reg[2][1]}
                     : HDR_BYTES;

    // Next scan state for the byte leaving the input register.
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            window_next[i] = window_reg[i];
        end
        fill_next  = fill_reg;
        skip_next  = skip_reg;
        total_next = total_reg;

        if (skip_reg != '0)
        begin
            // Drop frame body bytes.
            skip_next = skip_reg - 1'b1;
        end
        else if (fill_reg < FILL_W'(WIN_DEPTH))
        begin
            window_next[fill_reg] = s1_byte_reg;
            fill_next = fill_reg + 1'b1;
        end
        else if (hdr_ok)
        begin
            total_next = total_reg + hdr_samples;
            skip_next  = frame_len - HDR_BYTES;
            fill_next  = '0;
        end
        else
        begin
            // Resync one byte on.
            window_next[0] = window_reg[1];
            window_next[1] = window_reg[2];
            window_next[2] = s1_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            fill_reg  <= '0;
            skip_reg  <= '0;
            total_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                // End of buffer: clear everything for the next stream.
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    window_reg[i] <= '0;
                end
                fill_reg  <= '0;
                skip_reg  <= '0;
                total_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    window_reg[i] <= window_next[i];
                end
                fill_reg  <= fill_next;
                skip_reg  <= skip_next;
                total_reg <= total_next;
            end
        end
    end

    // Result register: load on a last byte, hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_total_reg <= total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_total = out_total_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_skip_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != '0) |-> (fill_reg == '0))
        else $error("skip counter running with a filled window");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked last byte");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=>
        (total_reg == '0 && fill_reg == '0 && skip_reg == '0 && out_valid_reg))
        else $error("state not cleared after last byte");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_last_reg) |=>
        (total_reg == $past(total_reg)
         || total_reg == $past(total_reg) + SAMPLES_MPEG1
         || total_reg == $past(total_reg) + SAMPLES_MPEG2))
        else $error("total moved by an unexpected amount");

endmodule
